// File: rtl/pidmi_pkg.sv
`default_nettype none

package pidmi_pkg;

  // Default sample-interval scale: ticks of one microsecond per millisecond.
  localparam int unsigned TICKS_PER_MS = 1000;

  // Field and state widths.
  localparam int GainW  = 16;
  localparam int ErrW   = 16;
  localparam int CorrW  = 32;
  localparam int TicksW = 32;
  localparam int SumW   = 40;
  localparam int AccW   = 64;

  // Limits of the saturating error sum.
  localparam logic signed [SumW-1:0] SUM_MAX = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SUM_MIN = {1'b1, {(SumW-1){1'b0}}};

  // Item kinds carried in the mode field.
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_D = 2'd1,
    REG_GAIN_I = 2'd2
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV,
    ST_RATE,
    ST_LOAD,
    ST_MUL,
    ST_FIN
  } state_e;

  // Which gain product the shared adder is working on.
  typedef enum logic [1:0] {
    PH_P,
    PH_I,
    PH_D
  } phase_e;

  typedef struct packed {
    logic                   mode;
    logic signed [ErrW-1:0] error_value;
  } in_item_t;

  typedef struct packed {
    logic signed [CorrW-1:0] correction;
    logic                    saturated;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/pidmi_alu.sv
`default_nettype none

// Shared 64-bit adder/subtractor used by every divide and multiply step.
module pidmi_alu (
  input  wire logic [pidmi_pkg::AccW-1:0] a_i,
  input  wire logic [pidmi_pkg::AccW-1:0] b_i,
  input  wire logic                       sub_i,
  output logic      [pidmi_pkg::AccW-1:0] sum_o
);

  // Subtraction is addition of the inverted operand plus one.
  assign sum_o = a_i + (b_i ^ {pidmi_pkg::AccW{sub_i}}) + pidmi_pkg::AccW'(sub_i);

endmodule

`default_nettype wire

// File: rtl/pid_step_measured_interval.sv
`default_nettype none

// Channel   Direction  Payload                       Handshake
// cfg       in         cfg_index_i, cfg_wdata_i      cfg_we_i, no wait
// in        in         in_item_i (mode, error)       in_valid_i / in_stall_o
// out       out        out_item_o (correction, sat)  out_valid_o / out_stall_i
//
// A tick item is taken in idle and only counts the interval. A sample item runs 32
// restoring divide steps, skipped when no tick was counted since the last sample,
// and three 16-step shift-add gain products, all on one shared 64-bit adder.
// The input stalls while a sample is in work. Reset clears the gains, the sum,
// the last error and the tick counter. A waiting result does not stall ticks;
// a new sample's result holds in its final state until the output register frees.
module pid_step_measured_interval #(
  parameter int unsigned TicksPerMs = pidmi_pkg::TICKS_PER_MS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [15:0]            cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire pidmi_pkg::in_item_t    in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output pidmi_pkg::out_item_t        out_item_o
);

  localparam int GainW   = pidmi_pkg::GainW;
  localparam int ErrW    = pidmi_pkg::ErrW;
  localparam int CorrW   = pidmi_pkg::CorrW;
  localparam int TicksW  = pidmi_pkg::TicksW;
  localparam int SumW    = pidmi_pkg::SumW;
  localparam int AccW    = pidmi_pkg::AccW;
  localparam int CntW    = $clog2(TicksW);
  localparam int QW      = AccW - 8;

  localparam logic [15:0]     TicksK   = 16'(TicksPerMs);
  localparam logic [CntW-1:0] DivLast  = CntW'(TicksW - 1);
  localparam logic [CntW-1:0] MulLast  = CntW'(GainW - 1);

  pidmi_pkg::state_e state_q, state_d;
  pidmi_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]          cnt_q, cnt_d;

  logic signed [GainW-1:0]  gain_p_q, gain_d_q, gain_i_q;
  logic signed [ErrW-1:0]   prev_q, prev_d;
  logic [TicksW-1:0]        ticks_q, ticks_d;
  logic signed [SumW-1:0]   sum_q, sum_d;

  logic signed [ErrW-1:0]   err_q, err_d;
  logic                     neg_q, neg_d;
  logic [ErrW-1:0]          mag_q, mag_d;
  logic [TicksW-1:0]        quo_q, quo_d;
  logic [TicksW-1:0]        rem_q, rem_d;
  logic signed [CorrW-1:0]  rate_q, rate_d;
  logic                     hit_q, hit_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [AccW-1:0]          mcand_q, mcand_d;
  logic [GainW-1:0]         mplier_q, mplier_d;

  logic                     out_valid_q, out_valid_d;
  pidmi_pkg::out_item_t     out_item_q, out_item_d;

  logic                     in_acc;
  logic                     out_fire;
  logic                     fin_go;

  logic [AccW-1:0]          alu_a, alu_b, alu_sum;
  logic                     alu_sub;
  logic [TicksW:0]          div_shift;
  logic                     div_ge;

  logic signed [ErrW:0]     diff;
  logic signed [ErrW:0]     diff_neg;

  logic [QW-1:0]            q_trunc;
  logic                     q_fits;
  logic [CorrW-1:0]         corr;
  logic signed [SumW:0]     sum_ext;

  // Handshakes.
  assign in_stall_o  = (state_q != pidmi_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign fin_go      = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Operand selection for the shared adder.
  assign div_shift = {rem_q, quo_q[TicksW-1]};
  always_comb begin
    if (state_q == pidmi_pkg::ST_DIV) begin
      alu_a   = AccW'(div_shift);
      alu_b   = AccW'(ticks_q);
      alu_sub = 1'b1;
    end else begin
      alu_a   = acc_q;
      alu_b   = mcand_q;
      alu_sub = (cnt_q == MulLast);
    end
  end

  pidmi_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  // The trial subtraction stays non-negative when the divisor fits.
  assign div_ge = !alu_sum[AccW-1];

  // Error change against the last sample.
  assign diff     = (ErrW+1)'(in_item_i.error_value) - (ErrW+1)'(prev_q);
  assign diff_neg = '0 - diff;

  // Divide by 256 toward zero, then clip to 32 bits.
  assign q_trunc = acc_q[AccW-1:8] + QW'(acc_q[AccW-1] && (acc_q[7:0] != 8'd0));
  assign q_fits  = (&q_trunc[QW-1:CorrW-1]) || !(|q_trunc[QW-1:CorrW-1]);
  always_comb begin
    if (q_fits) begin
      corr = q_trunc[CorrW-1:0];
    end else if (q_trunc[QW-1]) begin
      corr = {1'b1, {(CorrW-1){1'b0}}};
    end else begin
      corr = {1'b0, {(CorrW-1){1'b1}}};
    end
  end

  // Error sum with one guard bit for the overflow check.
  assign sum_ext = (SumW+1)'(sum_q) + (SumW+1)'(err_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidmi_pkg::ST_IDLE: begin
        if (in_acc && in_item_i.mode == pidmi_pkg::MODE_SAMPLE) begin
          state_d = (ticks_q == '0) ? pidmi_pkg::ST_LOAD : pidmi_pkg::ST_SCALE;
        end
      end
      pidmi_pkg::ST_SCALE: state_d = pidmi_pkg::ST_DIV;
      pidmi_pkg::ST_DIV: begin
        if (cnt_q == DivLast) state_d = pidmi_pkg::ST_RATE;
      end
      pidmi_pkg::ST_RATE: state_d = pidmi_pkg::ST_LOAD;
      pidmi_pkg::ST_LOAD: state_d = pidmi_pkg::ST_MUL;
      pidmi_pkg::ST_MUL: begin
        if (cnt_q == MulLast && phase_q == pidmi_pkg::PH_D) state_d = pidmi_pkg::ST_FIN;
      end
      pidmi_pkg::ST_FIN: begin
        if (fin_go) state_d = pidmi_pkg::ST_IDLE;
      end
      default: state_d = pidmi_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs per state.
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    ticks_d     = ticks_q;
    sum_d       = sum_q;
    err_d       = err_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    rate_d      = rate_q;
    hit_d       = hit_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    out_item_d  = out_item_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;

    unique case (state_q)
      pidmi_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.mode == pidmi_pkg::MODE_TICK) begin
            // The interval counter holds at its top value.
            if (ticks_q != '1) ticks_d = ticks_q + TicksW'(1);
          end else begin
            err_d  = in_item_i.error_value;
            neg_d  = diff[ErrW];
            mag_d  = diff[ErrW] ? diff_neg[ErrW-1:0] : diff[ErrW-1:0];
            rate_d = '0;
            hit_d  = 1'b0;
            cnt_d  = '0;
          end
        end
      end
      pidmi_pkg::ST_SCALE: begin
        quo_d = TicksW'(mag_q) * TicksW'(TicksK);
        rem_d = '0;
        cnt_d = '0;
      end
      pidmi_pkg::ST_DIV: begin
        // One restoring divide step per cycle.
        rem_d = div_ge ? alu_sum[TicksW-1:0] : div_shift[TicksW-1:0];
        quo_d = {quo_q[TicksW-2:0], div_ge};
        cnt_d = cnt_q + CntW'(1);
      end
      pidmi_pkg::ST_RATE: begin
        // Apply the sign and clip the rate to 32 bits.
        if (!neg_q) begin
          if (quo_q[TicksW-1]) begin
            rate_d = {1'b0, {(CorrW-1){1'b1}}};
            hit_d  = 1'b1;
          end else begin
            rate_d = quo_q;
          end
        end else begin
          if (quo_q > {1'b1, {(TicksW-1){1'b0}}}) begin
            rate_d = {1'b1, {(CorrW-1){1'b0}}};
            hit_d  = 1'b1;
          end else begin
            rate_d = ~quo_q + TicksW'(1);
          end
        end
      end
      pidmi_pkg::ST_LOAD: begin
        acc_d    = '0;
        phase_d  = pidmi_pkg::PH_P;
        mcand_d  = AccW'(err_q);
        mplier_d = gain_p_q;
        cnt_d    = '0;
      end
      pidmi_pkg::ST_MUL: begin
        // Shift-add step; the top gain bit has negative weight.
        if (mplier_q[0]) acc_d = alu_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CntW'(1);
        if (cnt_q == MulLast) begin
          cnt_d = '0;
          unique case (phase_q)
            pidmi_pkg::PH_P: begin
              phase_d  = pidmi_pkg::PH_I;
              mcand_d  = AccW'(sum_q);
              mplier_d = gain_i_q;
            end
            pidmi_pkg::PH_I: begin
              phase_d  = pidmi_pkg::PH_D;
              mcand_d  = AccW'(rate_q);
              mplier_d = gain_d_q;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
      pidmi_pkg::ST_FIN: begin
        if (fin_go) begin
          out_valid_d           = 1'b1;
          out_item_d.correction = corr;
          out_item_d.saturated  = hit_q || !q_fits;
          if (sum_ext[SumW] != sum_ext[SumW-1]) begin
            sum_d = sum_ext[SumW] ? pidmi_pkg::SUM_MIN : pidmi_pkg::SUM_MAX;
          end else begin
            sum_d = sum_ext[SumW-1:0];
          end
          prev_d  = err_q;
          ticks_d = '0;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidmi_pkg::ST_IDLE;
      phase_q     <= pidmi_pkg::PH_P;
      cnt_q       <= '0;
      prev_q      <= '0;
      ticks_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      gain_p_q    <= '0;
      gain_d_q    <= '0;
      gain_i_q    <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      ticks_q     <= ticks_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pidmi_pkg::REG_GAIN_P: gain_p_q <= cfg_wdata_i;
          pidmi_pkg::REG_GAIN_D: gain_d_q <= cfg_wdata_i;
          pidmi_pkg::REG_GAIN_I: gain_i_q <= cfg_wdata_i;
          default: begin
            gain_p_q <= gain_p_q;
          end
        endcase
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    rate_q     <= rate_d;
    hit_q      <= hit_d;
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    out_item_q <= out_item_d;
  end

  // A sample item always starts the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.mode == pidmi_pkg::MODE_SAMPLE |=> state_q != pidmi_pkg::ST_IDLE)
    else $error("sample item did not start the sequencer");

  // A result appears only out of the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == pidmi_pkg::ST_FIN)
    else $error("result raised outside the final state");

  // The divide remainder stays below the counted interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pidmi_pkg::ST_DIV |-> rem_q < ticks_q)
    else $error("divide remainder not below divisor");

  // The interval counter does not move while a sample is in work, up to its final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != pidmi_pkg::ST_IDLE && state_q != pidmi_pkg::ST_FIN |=> $stable(ticks_q))
    else $error("interval counter changed during a sample");

endmodule

`default_nettype wire
